// ===== rtl/bpq_pkg.sv =====
package bpq_pkg;

   localparam int unsigned IdWidth       = 16;
   localparam int unsigned ValueWidth    = 8;
   localparam int unsigned PriWidth      = 4;
   localparam int unsigned StatusWidth   = 3;
   localparam int unsigned OccupWidth    = 4;

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_REMOVE = 1'b1;

   localparam logic [StatusWidth-1:0] STATUS_INSERTED = 3'd0;
   localparam logic [StatusWidth-1:0] STATUS_EVICTED  = 3'd1;
   localparam logic [StatusWidth-1:0] STATUS_DROPPED  = 3'd2;
   localparam logic [StatusWidth-1:0] STATUS_REMOVED  = 3'd3;
   localparam logic [StatusWidth-1:0] STATUS_EMPTY    = 3'd4;

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } bpq_state_type;

   typedef struct packed {
      logic capture;
      logic execute;
   } bpq_cmd_type;

endpackage

// ===== rtl/bpq_ctrl.sv =====
module bpq_ctrl
   import bpq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output bpq_cmd_type cmd
);

   bpq_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_stall   = 1'b1;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         S_EXEC: begin
            cmd.execute = !rsp_valid_ff || !rsp_stall;
         end
         default: ;
      endcase
   end

   // hold result until taken
   assign rsp_valid_in = cmd.execute | (rsp_valid_ff & rsp_stall);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/bpq_datapath.sv =====
module bpq_datapath
   import bpq_pkg::*;
#(
   parameter int unsigned DEPTH = 8
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  bpq_cmd_type            cmd,
   input  logic                   req_func,
   input  logic [IdWidth-1:0]     req_item_id,
   input  logic [ValueWidth-1:0]  req_item_value,
   input  logic [PriWidth-1:0]    req_item_priority,
   output logic [StatusWidth-1:0] rsp_status,
   output logic [IdWidth-1:0]     rsp_out_id,
   output logic [ValueWidth-1:0]  rsp_out_value,
   output logic [PriWidth-1:0]    rsp_out_priority,
   output logic [OccupWidth-1:0]  rsp_occupancy
);

   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] Full = CW'(DEPTH);

   logic                  func_ff;
   logic [IdWidth-1:0]    id_ff;
   logic [ValueWidth-1:0] value_ff;
   logic [PriWidth-1:0]   pri_ff;

   logic [CW-1:0] count_ff, count_in;

   logic [IdWidth-1:0]    slot_id_ff       [DEPTH];
   logic [ValueWidth-1:0] slot_value_ff    [DEPTH];
   logic [PriWidth-1:0]   slot_priority_ff [DEPTH];
   logic [IdWidth-1:0]    slot_id_in       [DEPTH];
   logic [ValueWidth-1:0] slot_value_in    [DEPTH];
   logic [PriWidth-1:0]   slot_priority_in [DEPTH];

   logic [StatusWidth-1:0] status_ff, status_in;
   logic [IdWidth-1:0]     out_id_ff, out_id_in;
   logic [ValueWidth-1:0]  out_value_ff, out_value_in;
   logic [PriWidth-1:0]    out_pri_ff, out_pri_in;

   logic [DEPTH-1:0] le;
   logic [DEPTH-1:0] le_prev;
   logic             empty;
   logic             full;
   logic             evict;
   logic [CW+3:0]    count_ext;

   always_comb begin
      for (int k = 0; k < DEPTH; k++) begin
         le[k] = (CW'(k) < count_ff) && (slot_priority_ff[k] <= pri_ff);
      end
   end

   assign le_prev = {le[DEPTH-2:0], 1'b1};
   assign empty   = (count_ff == '0);
   assign full    = (count_ff == Full);
   assign evict   = pri_ff < slot_priority_ff[DEPTH-1];

   always_comb begin
      slot_id_in       = slot_id_ff;
      slot_value_in    = slot_value_ff;
      slot_priority_in = slot_priority_ff;
      count_in         = count_ff;
      status_in        = STATUS_INSERTED;
      out_id_in        = '0;
      out_value_in     = '0;
      out_pri_in       = '0;
      if (func_ff == FUNC_REMOVE) begin
         if (empty) begin
            status_in = STATUS_EMPTY;
         end else begin
            status_in    = STATUS_REMOVED;
            out_id_in    = slot_id_ff[0];
            out_value_in = slot_value_ff[0];
            out_pri_in   = slot_priority_ff[0];
            count_in     = count_ff - CW'(1);
            // advance every entry toward the head
            for (int k = 0; k < DEPTH - 1; k++) begin
               slot_id_in[k]       = slot_id_ff[k+1];
               slot_value_in[k]    = slot_value_ff[k+1];
               slot_priority_in[k] = slot_priority_ff[k+1];
            end
         end
      end else if (!full || evict) begin
         if (full) begin
            status_in    = STATUS_EVICTED;
            out_id_in    = slot_id_ff[DEPTH-1];
            out_value_in = slot_value_ff[DEPTH-1];
            out_pri_in   = slot_priority_ff[DEPTH-1];
         end else begin
            count_in = count_ff + CW'(1);
         end
         if (!le[0]) begin
            slot_id_in[0]       = id_ff;
            slot_value_in[0]    = value_ff;
            slot_priority_in[0] = pri_ff;
         end
         for (int k = 1; k < DEPTH; k++) begin
            if (!le[k] && le_prev[k]) begin
               slot_id_in[k]       = id_ff;
               slot_value_in[k]    = value_ff;
               slot_priority_in[k] = pri_ff;
            end else if (!le[k]) begin
               slot_id_in[k]       = slot_id_ff[k-1];
               slot_value_in[k]    = slot_value_ff[k-1];
               slot_priority_in[k] = slot_priority_ff[k-1];
            end
         end
      end else begin
         status_in = STATUS_DROPPED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.execute) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff  <= req_func;
         id_ff    <= req_item_id;
         value_ff <= req_item_value;
         pri_ff   <= req_item_priority;
      end
      if (cmd.execute) begin
         slot_id_ff       <= slot_id_in;
         slot_value_ff    <= slot_value_in;
         slot_priority_ff <= slot_priority_in;
         status_ff        <= status_in;
         out_id_ff        <= out_id_in;
         out_value_ff     <= out_value_in;
         out_pri_ff       <= out_pri_in;
      end
   end

   assign count_ext = {4'b0000, count_ff};

   assign rsp_status       = status_ff;
   assign rsp_out_id       = out_id_ff;
   assign rsp_out_value    = out_value_ff;
   assign rsp_out_priority = out_pri_ff;
   assign rsp_occupancy    = count_ext[OccupWidth-1:0];

endmodule

// ===== rtl/bounded_priority_queue.sv =====
// Channel   Direction  Handshake               Payload
// req       in         req_valid / req_stall   func, item_id, item_value, item_priority
// rsp       out        rsp_valid / rsp_stall   status, out_id, out_value, out_priority,
//                                              occupancy
//
// Each request is first captured, then executed in the parallel compare and shift
// across all DEPTH entry cells.
// The result sits in an output register; a new request is captured while it waits,
// but its execute cycle holds until the previous result is taken.
// Synchronous active-high reset empties the queue; entry contents are not cleared.
module bounded_priority_queue
   import bpq_pkg::*;
#(
   parameter int unsigned DEPTH = 8
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_func,
   input  logic [IdWidth-1:0]     req_item_id,
   input  logic [ValueWidth-1:0]  req_item_value,
   input  logic [PriWidth-1:0]    req_item_priority,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [StatusWidth-1:0] rsp_status,
   output logic [IdWidth-1:0]     rsp_out_id,
   output logic [ValueWidth-1:0]  rsp_out_value,
   output logic [PriWidth-1:0]    rsp_out_priority,
   output logic [OccupWidth-1:0]  rsp_occupancy
);

   bpq_cmd_type cmd;

   bpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   bpq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_func          (req_func),
      .req_item_id       (req_item_id),
      .req_item_value    (req_item_value),
      .req_item_priority (req_item_priority),
      .rsp_status        (rsp_status),
      .rsp_out_id        (rsp_out_id),
      .rsp_out_value     (rsp_out_value),
      .rsp_out_priority  (rsp_out_priority),
      .rsp_occupancy     (rsp_occupancy)
   );

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import bpq_pkg::*;

   localparam int Depth         = 8;
   localparam int MaxGap        = 19;
   localparam int HoldCycles    = 300;
   localparam int WatchdogLimit = 2000;
   localparam int RandomItems   = 1900;

   typedef struct packed {
      logic [IdWidth-1:0]    id;
      logic [ValueWidth-1:0] value;
      logic [PriWidth-1:0]   prio;
   } queue_entry_type;

   typedef struct packed {
      logic [StatusWidth-1:0] status;
      logic [IdWidth-1:0]     id;
      logic [ValueWidth-1:0]  value;
      logic [PriWidth-1:0]    prio;
      logic [OccupWidth-1:0]  occupancy;
   } outcome_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic                   req_func = FUNC_INSERT;
   logic [IdWidth-1:0]     req_item_id = '0;
   logic [ValueWidth-1:0]  req_item_value = '0;
   logic [PriWidth-1:0]    req_item_priority = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [StatusWidth-1:0] rsp_status;
   logic [IdWidth-1:0]     rsp_out_id;
   logic [ValueWidth-1:0]  rsp_out_value;
   logic [PriWidth-1:0]    rsp_out_priority;
   logic [OccupWidth-1:0]  rsp_occupancy;

   queue_entry_type held[Depth];
   int              held_count = 0;
   outcome_type     expected_q[$];

   bit idle_on = 1'b1;
   int rsp_hold_request = 0;
   int rsp_wait = 0;
   int quiet_cycles = 0;
   int request_count = 0;
   int result_count = 0;
   int error_count = 0;
   int seen_inserted = 0;
   int seen_evicted = 0;
   int seen_dropped = 0;
   int seen_removed = 0;
   int seen_empty = 0;

   bounded_priority_queue #(
      .DEPTH(Depth)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_item_id      (req_item_id),
      .req_item_value   (req_item_value),
      .req_item_priority(req_item_priority),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_out_id       (rsp_out_id),
      .rsp_out_value    (rsp_out_value),
      .rsp_out_priority (rsp_out_priority),
      .rsp_occupancy    (rsp_occupancy)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void place_entry(queue_entry_type e);
      int pos;
      int k;
      pos = 0;
      while (pos < held_count && held[pos].prio <= e.prio) pos++;
      for (k = held_count; k > pos; k--) held[k] = held[k-1];
      held[pos] = e;
      held_count++;
   endfunction

   function automatic outcome_type apply_request(logic func, queue_entry_type e);
      outcome_type     r;
      queue_entry_type victim;
      int              k;
      r = '0;
      if (func == FUNC_REMOVE) begin
         if (held_count == 0) begin
            r.status = STATUS_EMPTY;
         end else begin
            r.status = STATUS_REMOVED;
            r.id     = held[0].id;
            r.value  = held[0].value;
            r.prio   = held[0].prio;
            for (k = 1; k < held_count; k++) held[k-1] = held[k];
            held_count--;
         end
      end else if (held_count < Depth) begin
         place_entry(e);
         r.status = STATUS_INSERTED;
      end else if (e.prio < held[Depth-1].prio) begin
         victim = held[Depth-1];
         held_count--;
         place_entry(e);
         r.status = STATUS_EVICTED;
         r.id     = victim.id;
         r.value  = victim.value;
         r.prio   = victim.prio;
      end else begin
         r.status = STATUS_DROPPED;
      end
      r.occupancy = OccupWidth'(held_count);
      return r;
   endfunction

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         expected_q.push_back(apply_request(req_func,
            '{req_item_id, req_item_value, req_item_priority}));
         request_count++;
      end
   end

   task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      $display("result %0d: %s got %0d expected %0d", result_count, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin : check_results
      outcome_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         result_count++;
         case (rsp_status)
            STATUS_INSERTED: seen_inserted++;
            STATUS_EVICTED:  seen_evicted++;
            STATUS_DROPPED:  seen_dropped++;
            STATUS_REMOVED:  seen_removed++;
            STATUS_EMPTY:    seen_empty++;
            default: ;
         endcase
         if (expected_q.size() == 0) begin
            report_mismatch("result with no request pending, status",
                            16'(rsp_status), 16'd0);
         end else begin
            want = expected_q.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", 16'(rsp_status), 16'(want.status));
            if (rsp_out_id !== want.id)
               report_mismatch("out_id", rsp_out_id, want.id);
            if (rsp_out_value !== want.value)
               report_mismatch("out_value", 16'(rsp_out_value), 16'(want.value));
            if (rsp_out_priority !== want.prio)
               report_mismatch("out_priority", 16'(rsp_out_priority), 16'(want.prio));
            if (rsp_occupancy !== want.occupancy)
               report_mismatch("occupancy", 16'(rsp_occupancy), 16'(want.occupancy));
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_hold_request > 0) begin
            rsp_wait = rsp_hold_request;
            rsp_hold_request = 0;
         end else if (rsp_valid && !rsp_stall) begin
            rsp_wait = idle_on ? $urandom_range(0, MaxGap) : 0;
         end
         if (rsp_wait > 0) begin
            rsp_stall <= 1'b1;
            rsp_wait--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= WatchdogLimit);
      $display("watchdog: no handshake for %0d cycles", WatchdogLimit);
      $display("bounded_priority_queue test failed");
      $finish;
   end

   task automatic send_request(logic func, logic [IdWidth-1:0] id,
                               logic [ValueWidth-1:0] val, logic [PriWidth-1:0] pri);
      int gap;
      gap = idle_on ? $urandom_range(0, MaxGap) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_func          <= func;
      req_item_id       <= id;
      req_item_value    <= val;
      req_item_priority <= pri;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic test_empty_remove();
      idle_on = 1'b1;
      send_request(FUNC_REMOVE, 16'hFFFF, 8'hFF, 4'hF);
      send_request(FUNC_REMOVE, 16'h0000, 8'h00, 4'h0);
   endtask

   task automatic test_fill_ordering();
      send_request(FUNC_INSERT, 16'hFFFF, 8'hFF, 4'd15);
      send_request(FUNC_INSERT, 16'h0000, 8'h00, 4'd0);
      send_request(FUNC_INSERT, 16'h1111, 8'h11, 4'd7);
      send_request(FUNC_INSERT, 16'h2222, 8'h22, 4'd7);
      send_request(FUNC_INSERT, 16'h3333, 8'h33, 4'd7);
      send_request(FUNC_INSERT, 16'hA5A5, 8'h5A, 4'd3);
      send_request(FUNC_INSERT, 16'h5A5A, 8'hA5, 4'd15);
      send_request(FUNC_INSERT, 16'h0F0F, 8'hF0, 4'd9);
   endtask

   task automatic test_full_queue();
      send_request(FUNC_INSERT, 16'hBEEF, 8'h01, 4'd15);
      send_request(FUNC_INSERT, 16'hCAFE, 8'h80, 4'd0);
      send_request(FUNC_INSERT, 16'hFFFF, 8'hFF, 4'd15);
   endtask

   task automatic test_drain_all();
      int k;
      for (k = 0; k < Depth + 1; k++)
         send_request(FUNC_REMOVE, 16'($urandom), 8'($urandom), 4'($urandom));
      wait_for_drain();
   endtask

   task automatic test_backpressure();
      int k;
      logic [31:0] bits;
      idle_on = 1'b0;
      rsp_hold_request = HoldCycles;
      for (k = 0; k < 24; k++) begin
         bits = $urandom;
         send_request(FUNC_INSERT, bits[15:0], bits[23:16], bits[27:24]);
      end
      wait_for_drain();
      idle_on = 1'b1;
   endtask

   task automatic test_random_traffic(int n_items);
      int sent;
      int bias;
      int lo;
      int hi;
      int k;
      int block_len;
      logic [31:0] bits;
      logic func;
      sent = 0;
      while (sent < n_items) begin
         case ($urandom_range(0, 3))
            0: bias = 15;
            1: bias = 50;
            2: bias = 85;
            default: bias = 97;
         endcase
         idle_on = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 1)) begin
            lo = 0;
            hi = 15;
         end else begin
            lo = $urandom_range(0, 12);
            hi = lo + 3;
         end
         block_len = $urandom_range(20, 60);
         for (k = 0; k < block_len && sent < n_items; k++) begin
            bits = $urandom;
            func = ($urandom_range(0, 99) < bias) ? FUNC_INSERT : FUNC_REMOVE;
            send_request(func, bits[15:0], bits[23:16], 4'($urandom_range(lo, hi)));
            sent++;
         end
         if ($urandom_range(0, 7) == 0) wait_for_drain();
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_empty_remove();
      test_fill_ordering();
      test_full_queue();
      test_drain_all();
      test_backpressure();
      test_random_traffic(RandomItems);
      wait_for_drain();
      repeat (20) @(posedge clock);
      if (expected_q.size() != 0)
         report_mismatch("results still pending at end, count",
                         16'(expected_q.size()), 16'd0);
      $display("covered %0d requests and %0d results, %0d mismatches",
               request_count, result_count, error_count);
      $display("statuses: inserted %0d, evicted %0d, dropped %0d, removed %0d, empty %0d",
               seen_inserted, seen_evicted, seen_dropped, seen_removed, seen_empty);
      if (error_count == 0) begin
         $display("bounded_priority_queue test passed");
      end else begin
         $display("bounded_priority_queue test failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/bpq_pkg.sv
rtl/bpq_ctrl.sv
rtl/bpq_datapath.sv
rtl/bounded_priority_queue.sv
verif/testbench.sv
